/* design/brtt_pkg.sv */
`default_nettype none

package brtt_pkg;

   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_EDIT   = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic        [1:0]  kind;
      logic        [31:0] start_offset;
      logic        [31:0] end_offset;
      logic signed [31:0] length_delta;
      logic        [3:0]  language;
      logic        [15:0] line_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [12:0] hit_start;
      logic [12:0] hit_length;
      logic [3:0]  hit_language;
      logic [4:0]  entries_held;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [3:0]  language;
   } entry_type;

endpackage

`default_nettype wire

/* design/byte_range_tag_table.sv */
// Ordered table of tagged byte ranges held in a single-port-write, registered-read memory.
// Append and clear go straight from the idle state to the finish state, which loads the
// result register once it is free. Edit and query walk the stored ranges one entry per
// cycle through the memory read port, and a query walk also pauses while a hit waits
// behind a result that has not been taken. A deletion closes up the table in the same walk
// by writing kept entries back at a trailing index. A new request is taken as soon as the
// previous result sits in the output register, even if that result is still waiting.
`default_nettype none

module byte_range_tag_table #(
   parameter int MAX_RANGES = 16,
   parameter int MAX_LINE   = 4096
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire brtt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output brtt_pkg::rsp_type rsp_payload
);

   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   brtt_pkg::entry_type mem [MAX_RANGES];
   brtt_pkg::entry_type mem_q_ff;

   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic        proc_valid_ff, proc_valid_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  status_ff, status_in;
   logic        neg_ff, neg_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] amt_ff, amt_in;
   logic [32:0] dend_ff, dend_in;
   logic [32:0] le_ff, le_in;
   logic [12:0] pend_start_ff, pend_start_in;
   logic [12:0] pend_length_ff, pend_length_in;
   logic [3:0]  pend_lang_ff, pend_lang_in;
   brtt_pkg::rsp_type rsp_ff, rsp_in, rsp_next;

   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   brtt_pkg::entry_type wr_data;
   logic                rsp_load;
   logic                out_free;
   logic                stall;

   logic [31:0] neg_delta;
   logic [31:0] cur_s, cur_e;
   logic [32:0] ins_s_sum, ins_e_sum;
   logic [31:0] sat_s, sat_e;
   logic [31:0] sub_s, sub_e;
   logic        keep;
   brtt_pkg::entry_type edit_entry;

   logic [31:0] lo_v;
   logic [32:0] hi_v;
   logic [32:0] is_v, ie_v, len_v;
   logic        q_hit;

   assign neg_delta = 32'(-req_payload.length_delta);
   assign cur_s     = mem_q_ff.range_start;
   assign cur_e     = mem_q_ff.range_end;
   assign ins_s_sum = {1'b0, cur_s} + {1'b0, amt_ff};
   assign ins_e_sum = {1'b0, cur_e} + {1'b0, amt_ff};
   assign sat_s     = ins_s_sum[32] ? 32'hFFFF_FFFF : ins_s_sum[31:0];
   assign sat_e     = ins_e_sum[32] ? 32'hFFFF_FFFF : ins_e_sum[31:0];
   assign sub_s     = cur_s - amt_ff;
   assign sub_e     = cur_e - amt_ff;

   always_comb begin
      edit_entry = mem_q_ff;
      keep       = 1'b1;
      if (!neg_ff) begin
         if (off_ff <= cur_s) begin
            edit_entry.range_start = sat_s;
            edit_entry.range_end   = sat_e;
         end else if (off_ff < cur_e) begin
            edit_entry.range_end = sat_e;
         end
      end else begin
         if (dend_ff <= {1'b0, cur_s}) begin
            edit_entry.range_start = sub_s;
            edit_entry.range_end   = sub_e;
         end else if (off_ff <= cur_s && dend_ff >= {1'b0, cur_e}) begin
            keep = 1'b0;
         end else if (off_ff <= cur_s) begin
            edit_entry.range_start = off_ff;
            edit_entry.range_end   = sub_e;
         end else if (off_ff < cur_e) begin
            edit_entry.range_end = (dend_ff >= {1'b0, cur_e}) ? off_ff : sub_e;
         end
      end
   end

   assign lo_v  = (cur_s > off_ff) ? cur_s : off_ff;
   assign hi_v  = ({1'b0, cur_e} < le_ff) ? {1'b0, cur_e} : le_ff;
   assign is_v  = {1'b0, lo_v} - {1'b0, off_ff};
   assign ie_v  = hi_v - {1'b0, off_ff};
   assign len_v = ie_v - is_v;
   assign q_hit = ({1'b0, cur_s} < le_ff) && (cur_e > off_ff) && (ie_v > is_v);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_idx_in      = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      proc_valid_in  = proc_valid_ff;
      pend_valid_in  = pend_valid_ff;
      kind_in        = kind_ff;
      status_in      = status_ff;
      neg_in         = neg_ff;
      off_in         = off_ff;
      amt_in         = amt_ff;
      dend_in        = dend_ff;
      le_in          = le_ff;
      pend_start_in  = pend_start_ff;
      pend_length_in = pend_length_ff;
      pend_lang_in   = pend_lang_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff[IW-1:0];
      wr_en          = 1'b0;
      wr_addr        = wr_idx_ff[IW-1:0];
      wr_data        = edit_entry;
      rsp_load       = 1'b0;
      rsp_next       = '0;
      out_free       = !rsp_valid_ff || rsp_ready;
      stall          = 1'b0;
      req_ready      = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_payload.kind;
               off_in    = req_payload.start_offset;
               neg_in    = req_payload.length_delta[31];
               amt_in    = req_payload.length_delta[31] ? neg_delta
                                                        : req_payload.length_delta;
               dend_in   = {1'b0, req_payload.start_offset} + {1'b0, neg_delta};
               le_in     = {1'b0, req_payload.start_offset}
                         + {17'd0, req_payload.line_length};
               status_in = brtt_pkg::STATUS_DONE;
               state_in  = S_FIN;
               unique case (req_payload.kind)
                  brtt_pkg::KIND_APPEND: begin
                     if (req_payload.start_offset >= req_payload.end_offset) begin
                        status_in = brtt_pkg::STATUS_EMPTY;
                     end else if (count_ff == CW'(MAX_RANGES)) begin
                        status_in = brtt_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IW-1:0];
                        wr_data  = '{range_start: req_payload.start_offset,
                                     range_end:   req_payload.end_offset,
                                     language:    req_payload.language};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  brtt_pkg::KIND_EDIT,
                  brtt_pkg::KIND_QUERY: begin
                     if (count_ff != '0
                         && !(req_payload.kind == brtt_pkg::KIND_EDIT
                              && req_payload.length_delta == '0)
                         && !(req_payload.kind == brtt_pkg::KIND_QUERY
                              && req_payload.line_length > 16'(MAX_LINE))) begin
                        state_in      = S_SCAN;
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        rd_idx_in     = CW'(1);
                        wr_idx_in     = '0;
                        proc_valid_in = 1'b1;
                     end
                  end
                  brtt_pkg::KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            stall = (kind_ff == brtt_pkg::KIND_QUERY) && proc_valid_ff && q_hit
                    && pend_valid_ff && !out_free;
            if (!stall) begin
               if (proc_valid_ff) begin
                  if (kind_ff == brtt_pkg::KIND_EDIT) begin
                     wr_en     = keep;
                     wr_idx_in = wr_idx_ff + CW'(keep);
                  end else if (q_hit) begin
                     if (pend_valid_ff) begin
                        rsp_load = 1'b1;
                        rsp_next = '{status:       brtt_pkg::STATUS_DONE,
                                     hit:          1'b1,
                                     hit_start:    pend_start_ff,
                                     hit_length:   pend_length_ff,
                                     hit_language: pend_lang_ff,
                                     entries_held: 5'(count_ff),
                                     last:         1'b0};
                     end
                     pend_valid_in  = 1'b1;
                     pend_start_in  = is_v[12:0];
                     pend_length_in = len_v[12:0];
                     pend_lang_in   = mem_q_ff.language;
                  end
               end else begin
                  if (kind_ff == brtt_pkg::KIND_EDIT) begin
                     count_in = wr_idx_ff;
                  end
                  state_in = S_FIN;
               end
               if (rd_idx_ff < count_ff) begin
                  rd_en         = 1'b1;
                  rd_idx_in     = rd_idx_ff + CW'(1);
                  proc_valid_in = 1'b1;
               end else begin
                  proc_valid_in = 1'b0;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
               if (kind_ff == brtt_pkg::KIND_QUERY && pend_valid_ff) begin
                  rsp_next = '{status:       brtt_pkg::STATUS_DONE,
                               hit:          1'b1,
                               hit_start:    pend_start_ff,
                               hit_length:   pend_length_ff,
                               hit_language: pend_lang_ff,
                               entries_held: 5'(count_ff),
                               last:         1'b1};
               end else begin
                  rsp_next = '{status:       status_ff,
                               hit:          1'b0,
                               hit_start:    13'd0,
                               hit_length:   13'd0,
                               hit_language: 4'd0,
                               entries_held: 5'(count_ff),
                               last:         1'b1};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_load ? rsp_next : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         proc_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         proc_valid_ff <= proc_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      wr_idx_ff      <= wr_idx_in;
      kind_ff        <= kind_in;
      status_ff      <= status_in;
      neg_ff         <= neg_in;
      off_ff         <= off_in;
      amt_ff         <= amt_in;
      dend_ff        <= dend_in;
      le_ff          <= le_in;
      pend_start_ff  <= pend_start_in;
      pend_length_ff <= pend_length_in;
      pend_lang_ff   <= pend_lang_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
module tb_top;

   localparam int TABLE_DEPTH = 16;
   localparam int LINE_LIMIT = 4096;
   localparam int RANDOM_ITEMS = 425;
   localparam int REP_STRIDE = 256;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT = 1_200_000;

   typedef struct {
      brtt_pkg::req_type item;
      int                reps;
      bit                typed;
      logic [1:0]        want_status;
      logic [4:0]        want_held;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   brtt_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   brtt_pkg::rsp_type rsp_payload;

   logic [31:0] tbl_start [TABLE_DEPTH];
   logic [31:0] tbl_end [TABLE_DEPTH];
   logic [3:0]  tbl_lang [TABLE_DEPTH];
   int          tbl_count = 0;

   brtt_pkg::rsp_type awaited_rsp [$];
   plan_row_type      plan [$];

   int cycle_count = 0;
   int fail_count = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int accepted_items = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   int rsp_gap = 0;
   bit rsp_calm = 1'b0;
   bit rsp_hold = 1'b0;

   byte_range_tag_table #(
      .MAX_RANGES(TABLE_DEPTH),
      .MAX_LINE(LINE_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] sat_shift(input logic [31:0] v, input logic [31:0] n);
      logic [32:0] s;
      s = {1'b0, v} + {1'b0, n};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void drop_entry(input int idx);
      for (int j = idx; j + 1 < tbl_count; j++) begin
         tbl_start[j] = tbl_start[j + 1];
         tbl_end[j] = tbl_end[j + 1];
         tbl_lang[j] = tbl_lang[j + 1];
      end
      tbl_count--;
   endfunction

   function automatic void apply_edit(input logic [31:0] off, input logic [31:0] delta);
      logic [32:0] del;
      logic [32:0] del_end;
      logic [32:0] s;
      logic [32:0] e;
      int i;
      if (delta == 32'd0) return;
      if (!delta[31]) begin
         for (i = 0; i < tbl_count; i++) begin
            if (off <= tbl_start[i]) begin
               tbl_start[i] = sat_shift(tbl_start[i], delta);
               tbl_end[i] = sat_shift(tbl_end[i], delta);
            end else if (off < tbl_end[i]) begin
               tbl_end[i] = sat_shift(tbl_end[i], delta);
            end
         end
         return;
      end
      del = {1'b0, ~delta + 32'd1};
      del_end = {1'b0, off} + del;
      i = 0;
      while (i < tbl_count) begin
         s = {1'b0, tbl_start[i]};
         e = {1'b0, tbl_end[i]};
         if (del_end <= s) begin
            tbl_start[i] = 32'(s - del);
            tbl_end[i] = 32'(e - del);
            i++;
         end else if ({1'b0, off} <= s && del_end >= e) begin
            drop_entry(i);
         end else begin
            if ({1'b0, off} <= s) begin
               tbl_start[i] = off;
               tbl_end[i] = 32'(e - del);
            end else if ({1'b0, off} < e) begin
               tbl_end[i] = (del_end >= e) ? off : 32'(e - del);
            end
            i++;
         end
      end
   endfunction

   function automatic void query_line(input logic [31:0] line_start, input logic [15:0] len,
                                      ref brtt_pkg::rsp_type out [$]);
      logic [32:0] ls;
      logic [32:0] le;
      logic [32:0] s;
      logic [32:0] e;
      logic [32:0] lo;
      logic [32:0] hi;
      brtt_pkg::rsp_type r;
      if (len > 16'(LINE_LIMIT)) return;
      ls = {1'b0, line_start};
      le = ls + {17'd0, len};
      for (int i = 0; i < tbl_count; i++) begin
         s = {1'b0, tbl_start[i]};
         e = {1'b0, tbl_end[i]};
         if (s < le && e > ls) begin
            lo = ((s > ls) ? s : ls) - ls;
            hi = ((e < le) ? e : le) - ls;
            if (hi > lo) begin
               r = '0;
               r.status = brtt_pkg::STATUS_DONE;
               r.hit = 1'b1;
               r.hit_start = lo[12:0];
               r.hit_length = 13'(hi - lo);
               r.hit_language = tbl_lang[i];
               r.entries_held = 5'(tbl_count);
               out.push_back(r);
            end
         end
      end
   endfunction

   function automatic void step_range_table(input brtt_pkg::req_type rq,
                                            ref brtt_pkg::rsp_type out [$]);
      brtt_pkg::rsp_type r;
      r = '0;
      r.status = brtt_pkg::STATUS_DONE;
      r.last = 1'b1;
      out.delete();
      case (rq.kind)
         brtt_pkg::KIND_APPEND: begin
            if (rq.start_offset >= rq.end_offset) begin
               r.status = brtt_pkg::STATUS_EMPTY;
            end else if (tbl_count >= TABLE_DEPTH) begin
               r.status = brtt_pkg::STATUS_FULL;
            end else begin
               tbl_start[tbl_count] = rq.start_offset;
               tbl_end[tbl_count] = rq.end_offset;
               tbl_lang[tbl_count] = rq.language;
               tbl_count++;
            end
         end
         brtt_pkg::KIND_EDIT: apply_edit(rq.start_offset, rq.length_delta);
         brtt_pkg::KIND_CLEAR: tbl_count = 0;
         default: query_line(rq.start_offset, rq.line_length, out);
      endcase
      if (out.size() == 0) begin
         r.entries_held = 5'(tbl_count);
         out.push_back(r);
      end else begin
         out[out.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic brtt_pkg::req_type random_request();
      brtt_pkg::req_type rq;
      int roll;
      int pick;
      rq.kind = brtt_pkg::KIND_CLEAR;
      rq.start_offset = $urandom();
      rq.end_offset = $urandom();
      rq.length_delta = $urandom();
      rq.language = 4'($urandom());
      rq.line_length = 16'($urandom());
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 19);
      if (roll < 36) begin
         rq.kind = brtt_pkg::KIND_APPEND;
         if (pick < 2) begin
            rq.end_offset = rq.start_offset - 32'($urandom_range(0, 3));
         end else if (pick > 2) begin
            rq.start_offset = $urandom_range(0, 9000);
            rq.end_offset = rq.start_offset + 32'($urandom_range(1, 700));
         end
      end else if (roll < 62) begin
         rq.kind = brtt_pkg::KIND_EDIT;
         if ($urandom_range(0, 9) != 0) rq.start_offset = $urandom_range(0, 9000);
         if (pick == 0) rq.length_delta = 32'sd0;
         else if (pick < 10) rq.length_delta = $urandom_range(1, 600);
         else if (pick < 19) rq.length_delta = -$urandom_range(1, 600);
      end else if (roll < 97) begin
         rq.kind = brtt_pkg::KIND_QUERY;
         if (pick == 1) begin
            rq.line_length = 16'($urandom_range(LINE_LIMIT + 1, 65535));
         end else if (pick > 1) begin
            rq.start_offset = $urandom_range(0, 9000);
            rq.line_length = (pick == 2) ? 16'(LINE_LIMIT)
                                         : 16'($urandom_range(0, LINE_LIMIT));
         end
      end
      return rq;
   endfunction

   task automatic add_row(input logic [1:0] kind, input logic [31:0] a, input logic [31:0] b,
                          input logic [31:0] d, input logic [3:0] lang, input logic [15:0] llen,
                          input int reps, input bit typed, input logic [1:0] st,
                          input logic [4:0] held);
      plan_row_type row;
      row.item.kind = kind;
      row.item.start_offset = a;
      row.item.end_offset = b;
      row.item.length_delta = d;
      row.item.language = lang;
      row.item.line_length = llen;
      row.reps = reps;
      row.typed = typed;
      row.want_status = st;
      row.want_held = held;
      plan.push_back(row);
   endtask

   task automatic flag_mismatch(input string what);
      fail_count++;
      $display("mismatch in result %0d at cycle %0d: %s", results_seen, cycle_count, what);
   endtask

   task automatic check_rsp(input brtt_pkg::rsp_type got);
      brtt_pkg::rsp_type want;
      results_seen++;
      if (got.hit) hits_seen++;
      if (awaited_rsp.size() == 0) begin
         flag_mismatch("result arrived with nothing expected");
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status)
         flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.hit !== want.hit)
         flag_mismatch($sformatf("hit %0d, expected %0d", got.hit, want.hit));
      if (got.hit_start !== want.hit_start)
         flag_mismatch($sformatf("hit_start %0d, expected %0d", got.hit_start, want.hit_start));
      if (got.hit_length !== want.hit_length)
         flag_mismatch($sformatf("hit_length %0d, expected %0d", got.hit_length,
                                 want.hit_length));
      if (got.hit_language !== want.hit_language)
         flag_mismatch($sformatf("hit_language %0d, expected %0d", got.hit_language,
                                 want.hit_language));
      if (got.entries_held !== want.entries_held)
         flag_mismatch($sformatf("entries_held %0d, expected %0d", got.entries_held,
                                 want.entries_held));
      if (got.last !== want.last)
         flag_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
   endtask

   // The valid stays high across back-to-back transfers and is only lowered for a gap.
   task automatic offer(input brtt_pkg::req_type rq, input int gap, input bit typed,
                        input brtt_pkg::rsp_type want);
      brtt_pkg::rsp_type fresh [$];
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_range_table(rq, fresh);
      if (typed) awaited_rsp.push_back(want);
      else foreach (fresh[k]) awaited_rsp.push_back(fresh[k]);
      kind_count[rq.kind]++;
      accepted_items++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_rsp(rsp_payload);
         if (rsp_hold || rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            if (!rsp_hold) rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_calm) rsp_gap <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 128 == 0) rsp_calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results still expected", cycle_count,
                  awaited_rsp.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver stalls for a long stretch while requests keep coming, so the block backs up.
   initial begin
      wait (accepted_items >= 80);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      brtt_pkg::req_type rq;
      brtt_pkg::rsp_type want;
      plan_row_type      row;
      bit                burst;
      add_row(brtt_pkg::KIND_QUERY, 32'd0, 32'd0, 32'd0, 4'd0, 16'd4096, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd0, 32'd0, 32'd5, 4'd0, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_APPEND, 32'd5, 32'd5, 32'd0, 4'd3, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_EMPTY, 5'd0);
      add_row(brtt_pkg::KIND_APPEND, 32'd10, 32'd5, 32'd0, 4'd3, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_EMPTY, 5'd0);
      add_row(brtt_pkg::KIND_APPEND, 32'd0, 32'hFFFF_FFFF, 32'd0, 4'd15, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd1);
      add_row(brtt_pkg::KIND_APPEND, 32'd100, 32'd200, 32'd0, 4'd1, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd2);
      add_row(brtt_pkg::KIND_APPEND, 32'd4000, 32'd5000, 32'd0, 4'd2, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd3);
      add_row(brtt_pkg::KIND_QUERY, 32'd0, 32'd0, 32'd0, 4'd0, 16'd4096, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_QUERY, 32'd0, 32'd0, 32'd0, 4'd0, 16'd4097, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd3);
      add_row(brtt_pkg::KIND_QUERY, 32'd50, 32'd0, 32'd0, 4'd0, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd3);
      add_row(brtt_pkg::KIND_QUERY, 32'hFFFF_F000, 32'd0, 32'd0, 4'd0, 16'd4096, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd150, 32'd0, 32'd0, 4'd0, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd3);
      add_row(brtt_pkg::KIND_EDIT, 32'd150, 32'd0, 32'd50, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd0, 32'd0, 32'h7FFF_FFFF, 4'd0, 16'd0, 2, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_QUERY, 32'hFFFF_F000, 32'd0, 32'd0, 4'd0, 16'd4096, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd0, 32'd0, 32'h8000_0000, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_QUERY, 32'd0, 32'd0, 32'd0, 4'd0, 16'hFFFF, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_CLEAR, 32'd0, 32'd0, 32'd0, 4'd0, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_APPEND, 32'd16, 32'd116, 32'd0, 4'd0, 16'd0, TABLE_DEPTH, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_APPEND, 32'd5000, 32'd6000, 32'd0, 4'd7, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_FULL, 5'd16);
      add_row(brtt_pkg::KIND_APPEND, 32'd7, 32'd7, 32'd0, 4'd7, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_EMPTY, 5'd16);
      add_row(brtt_pkg::KIND_QUERY, 32'd0, 32'd0, 32'd0, 4'd0, 16'd4096, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd300, 32'd0, -32'sd100, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd0, 32'd0, -32'sd300, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd600, 32'd0, -32'sd20, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'd500, 32'd0, -32'sd700, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_EDIT, 32'hFFFF_FFFF, 32'd0, -32'sd1, 4'd0, 16'd0, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_QUERY, 32'd16, 32'd0, 32'd0, 4'd0, 16'd4096, 1, 1'b0,
              brtt_pkg::STATUS_DONE, 5'd0);
      add_row(brtt_pkg::KIND_CLEAR, 32'd0, 32'd0, 32'd0, 4'd0, 16'd0, 1, 1'b1,
              brtt_pkg::STATUS_DONE, 5'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[p]) begin
         row = plan[p];
         want = '0;
         want.status = row.want_status;
         want.entries_held = row.want_held;
         want.last = 1'b1;
         for (int r = 0; r < row.reps; r++) begin
            rq = row.item;
            if (row.reps > 1 && rq.kind == brtt_pkg::KIND_APPEND) begin
               rq.start_offset = row.item.start_offset + 32'(r * REP_STRIDE);
               rq.end_offset = row.item.end_offset + 32'(r * REP_STRIDE);
               rq.language = 4'(r);
            end
            offer(rq, pick_gap(), row.typed, want);
         end
      end

      burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) burst = ($urandom_range(0, 3) == 0);
         offer(random_request(), burst ? 0 : pick_gap(), 1'b0, want);
      end
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d appends, %0d edits, %0d queries, %0d clears.",
               accepted_items, kind_count[brtt_pkg::KIND_APPEND],
               kind_count[brtt_pkg::KIND_EDIT], kind_count[brtt_pkg::KIND_QUERY],
               kind_count[brtt_pkg::KIND_CLEAR]);
      $display("Checked %0d results, %0d of them range hits, with %0d mismatches.",
               results_seen, hits_seen, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/brtt_pkg.sv
design/byte_range_tag_table.sv
verif/tb_top.sv
